// ===== rtl/text_console_writer_defines.svh =====
// Assertion helpers used by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console check failed");

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console check failed");

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;

   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int CELL_W     = 16;
   localparam int COLOUR_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int TAB_STOP   = 8;

   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

   localparam logic [COLOUR_W-1:0] FG_RESET = 4'd7;
   localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

   localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CODE_SPACE};

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOUR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOUR = 2'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   // Command to the cursor unit.
   typedef struct packed {
      logic              advance;
      logic              home;
      logic [CHAR_W-1:0] character;
   } cursor_cmd_type;

endpackage

// ===== rtl/text_console_writer.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  func, character, read_row, read_col
// rsp       out        rsp_valid / rsp_ready  cell_value, cursor_row, cursor_col, scrolled
// csr       in         csr_wr_en              csr_index, csr_wdata
//
// A read goes through the registered screen memory read port. Clear and a put that
// scrolls each make one memory write per cycle over the whole screen.
// After reset the block blanks the whole screen memory with req_ready low; csr writes
// are taken during that pass.
// One item is worked on at a time; the next item is taken while a result waits in the
// output register, and the block stalls only when a second result finds it still full.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAR_W-1:0]     req_character,
   input  logic [ROW_PORT_W-1:0] req_read_row,
   input  logic [COL_PORT_W-1:0] req_read_col,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CELL_W-1:0]     rsp_cell_value,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [COL_PORT_W-1:0] rsp_cursor_col,
   output logic                  rsp_scrolled,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COLOUR_W-1:0]   csr_wdata
);

   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int COL_W  = $clog2(SCREEN_WIDTH);

   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - SCREEN_WIDTH);

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_EXEC   = 8'b0000_0100,
      ST_RDATA  = 8'b0000_1000,
      ST_FILL   = 8'b0001_0000,
      ST_SCROLL = 8'b0010_0000,
      ST_BLANK  = 8'b0100_0000,
      ST_HOLD   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;

   // Item held while it is worked on
   logic [FUNC_W-1:0]     func_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [ROW_PORT_W-1:0] rrow_ff;
   logic [COL_PORT_W-1:0] rcol_ff;

   logic [COLOUR_W-1:0] fg_ff, bg_ff;

   // Output register and the slot for a result that found it full
   logic                  rsp_valid_ff;
   logic [CELL_W-1:0]     rsp_cell_ff;
   logic [ROW_PORT_W-1:0] rsp_row_ff;
   logic [COL_PORT_W-1:0] rsp_col_ff;
   logic                  rsp_scr_ff;
   logic [CELL_W-1:0]     hold_cell_ff;
   logic                  hold_scr_ff;

   // Cursor unit
   cursor_cmd_type   cur_cmd;
   logic [ROW_W-1:0] cur_row, cur_row_next;
   logic [COL_W-1:0] cur_col, cur_col_next;
   logic             scroll_need;

   // Memory ports
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata, mem_rdata;

   logic [CELL_W-1:0] blank, put_cell;
   logic [CHAR_W-1:0] put_code;
   logic [ADDR_W-1:0] cursor_addr, read_addr;
   logic              read_ok, out_free, accept;
   logic              fin, load_out;
   logic [CELL_W-1:0] fin_cell;
   logic              fin_scr;

   tcw_cursor #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .ROW_W        (ROW_W),
      .COL_W        (COL_W)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cur_cmd),
      .row        (cur_row),
      .col        (cur_col),
      .row_next   (cur_row_next),
      .col_next   (cur_col_next),
      .scroll_need(scroll_need)
   );

   tcw_screen_mem #(
      .DEPTH (CELLS),
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // Datapath helpers
   always_comb begin
      blank    = {bg_ff, fg_ff, CODE_SPACE};
      put_code = (char_ff == CODE_NEWLINE || char_ff == CODE_TAB) ? CODE_SPACE : char_ff;
      put_cell = {bg_ff, fg_ff, put_code};
      cursor_addr = ADDR_W'(32'(cur_row) * 32'(SCREEN_WIDTH) + 32'(cur_col));
      read_addr   = ADDR_W'(32'(rrow_ff) * 32'(SCREEN_WIDTH) + 32'(rcol_ff));
      read_ok     = (32'(rrow_ff) < 32'(SCREEN_HEIGHT)) && (32'(rcol_ff) < 32'(SCREEN_WIDTH));
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == ST_IDLE);
      accept      = req_valid && req_ready;
   end

   // Sequencer: memory traffic, cursor commands and result completion
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = blank;
      mem_re    = 1'b0;
      mem_raddr = read_addr;
      cur_cmd   = '{advance: 1'b0, home: 1'b0, character: char_ff};
      fin       = 1'b0;
      fin_cell  = '0;
      fin_scr   = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // Blank with the reset attribute, not the live one.
            mem_we    = 1'b1;
            mem_wdata = RESET_BLANK;
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (func_ff)
               FUNC_PUT: begin
                  mem_we          = 1'b1;
                  mem_waddr       = cursor_addr;
                  mem_wdata       = put_cell;
                  cur_cmd.advance = 1'b1;
                  cnt_in          = '0;
                  if (scroll_need) begin
                     state_in = ST_SCROLL;
                  end else begin
                     fin = 1'b1;
                  end
               end
               FUNC_CLEAR: begin
                  cur_cmd.home = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_FILL;
               end
               FUNC_READ: begin
                  mem_re   = 1'b1;
                  state_in = ST_RDATA;
               end
               default: begin
                  // Unused code: report the cursor, touch nothing.
                  fin = 1'b1;
               end
            endcase
         end
         ST_RDATA: begin
            fin      = 1'b1;
            fin_cell = read_ok ? mem_rdata : '0;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               fin = 1'b1;
            end
         end
         ST_SCROLL: begin
            // cnt + SCREEN_WIDTH is the cell being fetched; its data lands one row up, at cnt, the cycle after.
            mem_we    = (cnt_ff != '0);
            mem_waddr = cnt_ff - ADDR_W'(1);
            mem_wdata = mem_rdata;
            mem_raddr = cnt_ff + ADDR_W'(SCREEN_WIDTH);
            if (cnt_ff == BOTTOM_ROW) begin
               // Last copy written; blank the bottom row from here.
               state_in = ST_BLANK;
            end else begin
               mem_re = 1'b1;
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_CELL) begin
               fin     = 1'b1;
               fin_scr = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end
      load_out = (fin || (state_ff == ST_HOLD)) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FG_COLOUR: fg_ff <= csr_wdata;
               CSR_BG_COLOUR: bg_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload: item capture, parked result, output register
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         char_ff <= req_character;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      if (fin && !out_free) begin
         hold_cell_ff <= fin_cell;
         hold_scr_ff  <= fin_scr;
      end
      if (load_out) begin
         // Cursor is stable while parked, so next equals current in ST_HOLD.
         rsp_cell_ff <= fin ? fin_cell : hold_cell_ff;
         rsp_scr_ff  <= fin ? fin_scr : hold_scr_ff;
         rsp_row_ff  <= ROW_PORT_W'(cur_row_next);
         rsp_col_ff  <= COL_PORT_W'(cur_col_next);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // The cursor never leaves the screen.
   `TCW_ASSERT_NOW(a_cursor_on_screen, clock, reset, 1'b1,
      (32'(cur_row) < 32'(SCREEN_HEIGHT)) && (32'(cur_col) < 32'(SCREEN_WIDTH)))
   // A scroll leaves the cursor at the start of the bottom row.
   `TCW_ASSERT_NOW(a_scroll_cursor, clock, reset, rsp_valid && rsp_scrolled,
      (rsp_cursor_row == ROW_PORT_W'(SCREEN_HEIGHT - 1)) && (rsp_cursor_col == '0))
   // No memory write while waiting for an item.
   `TCW_ASSERT_NOW(a_idle_quiet, clock, reset, state_ff == ST_IDLE, !mem_we)
   // A completed pass leaves a result behind in the output register.
   `TCW_ASSERT_NEXT(a_fin_loads, clock, reset, fin, rsp_valid)

endmodule

// ===== rtl/tcw_screen_mem.sv =====
module tcw_screen_mem import tcw_pkg::*; #(
   parameter int DEPTH  = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] screen_mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcw_cursor.sv =====
module tcw_cursor import tcw_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int ROW_W         = $clog2(SCREEN_HEIGHT),
   parameter int COL_W         = $clog2(SCREEN_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  cursor_cmd_type   cmd,
   output logic [ROW_W-1:0] row,
   output logic [COL_W-1:0] col,
   output logic [ROW_W-1:0] row_next,
   output logic [COL_W-1:0] col_next,
   output logic             scroll_need
);

   // Wide enough for column + 1 rounded up past the next tab stop.
   localparam int NCOL_W = $clog2(SCREEN_WIDTH + TAB_STOP + 1);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [NCOL_W-1:0] col_inc, col_tab, col_adv;
   logic              is_tab, is_nl, wrap, last_row;

   always_comb begin
      is_tab   = (cmd.character == CODE_TAB);
      is_nl    = (cmd.character == CODE_NEWLINE);
      col_inc  = NCOL_W'(col_ff) + NCOL_W'(1);
      col_tab  = (col_inc & ~NCOL_W'(TAB_STOP - 1)) + NCOL_W'(TAB_STOP);
      col_adv  = is_tab ? col_tab : col_inc;
      wrap     = (col_adv >= NCOL_W'(SCREEN_WIDTH)) || is_nl;
      last_row = (row_ff == ROW_W'(SCREEN_HEIGHT - 1));

      row_in = row_ff;
      col_in = col_ff;
      priority if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.advance) begin
         if (wrap) begin
            col_in = '0;
            // Hold the row on the bottom line; the screen moves instead.
            row_in = last_row ? row_ff : row_ff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_adv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row         = row_ff;
   assign col         = col_ff;
   assign row_next    = row_in;
   assign col_next    = col_in;
   assign scroll_need = wrap && last_row;

endmodule
